/* design/skt_pkg.sv */
// Shared types and constants for the three-axis scalar Kalman filter.
package skt_pkg;

  typedef logic [2:0] pc_t;
  typedef logic [4:0] cnt_t;

  localparam pc_t PC_IDLE = 3'd0;
  localparam pc_t PC_PRED = 3'd1;
  localparam pc_t PC_DIV  = 3'd2;
  localparam pc_t PC_MULI = 3'd3;
  localparam pc_t PC_MUL  = 3'd4;
  localparam pc_t PC_WB   = 3'd5;
  localparam pc_t PC_OUT  = 3'd6;

  localparam cnt_t DIV_ITER_LAST = 5'd29;
  localparam cnt_t MUL_ITER_LAST = 5'd30;

  localparam logic REG_PROCESS_NOISE     = 1'b0;
  localparam logic REG_MEASUREMENT_NOISE = 1'b1;

  localparam logic [31:0] PROCESS_NOISE_RESET     = 32'd107374182;
  localparam logic [31:0] MEASUREMENT_NOISE_RESET = 32'd107374;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LATCH = 3'd1,
    OP_PRED  = 3'd2,
    OP_DIV   = 3'd3,
    OP_MULI  = 3'd4,
    OP_MUL   = 3'd5,
    OP_WB    = 3'd6,
    OP_OUT   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_WAIT_IN  = 3'd1,
    COND_BAD      = 3'd2,
    COND_LOOP     = 3'd3,
    COND_WAIT_OUT = 3'd4,
    COND_ALWAYS   = 3'd5
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
    logic  cnt_ld;
    cnt_t  cnt_val;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic go;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic bad;
  } seq_stat_t;

endpackage

/* design/skt_ucode_rom.sv */
// Read-only control store holding the filter update program.
module skt_ucode_rom (
  input  skt_pkg::pc_t    pc_i,
  output skt_pkg::uword_t uword_o
);
  import skt_pkg::*;

  always_comb begin
    uword_o = '{op: OP_NONE, cond: COND_ALWAYS, target: PC_IDLE, cnt_ld: 1'b0, cnt_val: '0};
    case (pc_i)
      PC_IDLE: begin
        uword_o = '{op: OP_LATCH, cond: COND_WAIT_IN, target: PC_IDLE, cnt_ld: 1'b0,
                    cnt_val: '0};
      end
      PC_PRED: begin
        uword_o = '{op: OP_PRED, cond: COND_BAD, target: PC_OUT, cnt_ld: 1'b1,
                    cnt_val: DIV_ITER_LAST};
      end
      PC_DIV: begin
        uword_o = '{op: OP_DIV, cond: COND_LOOP, target: PC_DIV, cnt_ld: 1'b0,
                    cnt_val: '0};
      end
      PC_MULI: begin
        uword_o = '{op: OP_MULI, cond: COND_NEXT, target: PC_IDLE, cnt_ld: 1'b1,
                    cnt_val: MUL_ITER_LAST};
      end
      PC_MUL: begin
        uword_o = '{op: OP_MUL, cond: COND_LOOP, target: PC_MUL, cnt_ld: 1'b0,
                    cnt_val: '0};
      end
      PC_WB: begin
        uword_o = '{op: OP_WB, cond: COND_NEXT, target: PC_IDLE, cnt_ld: 1'b0,
                    cnt_val: '0};
      end
      PC_OUT: begin
        uword_o = '{op: OP_OUT, cond: COND_WAIT_OUT, target: PC_IDLE, cnt_ld: 1'b0,
                    cnt_val: '0};
      end
      default: begin
        uword_o = '{op: OP_NONE, cond: COND_ALWAYS, target: PC_IDLE, cnt_ld: 1'b0,
                    cnt_val: '0};
      end
    endcase
  end

endmodule

/* design/skt_sequencer.sv */
// Microcode sequencer: step counter, loop counter and conditional jumps.
module skt_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skt_pkg::seq_stat_t stat_i,
  output skt_pkg::ctrl_t     ctrl_o
);
  import skt_pkg::*;

  pc_t    pc_q, pc_d;
  cnt_t   cnt_q, cnt_d;
  uword_t uw;
  logic   go;
  pc_t    pc_inc;

  skt_ucode_rom u_rom (
    .pc_i    (pc_q),
    .uword_o (uw)
  );

  assign pc_inc = pc_t'(pc_q + 3'd1);

  always_comb begin
    go    = 1'b1;
    pc_d  = pc_q;
    cnt_d = cnt_q;
    case (uw.cond)
      COND_NEXT: begin
        pc_d = pc_inc;
      end
      COND_WAIT_IN: begin
        go   = stat_i.in_fire;
        pc_d = stat_i.in_fire ? pc_inc : pc_q;
      end
      COND_BAD: begin
        pc_d = stat_i.bad ? uw.target : pc_inc;
      end
      COND_LOOP: begin
        if (cnt_q != '0) begin
          pc_d  = uw.target;
          cnt_d = cnt_t'(cnt_q - 5'd1);
        end else begin
          pc_d = pc_inc;
        end
      end
      COND_WAIT_OUT: begin
        go   = stat_i.out_free;
        pc_d = stat_i.out_free ? uw.target : pc_q;
      end
      COND_ALWAYS: begin
        pc_d = uw.target;
      end
      default: begin
        go   = 1'b0;
        pc_d = PC_IDLE;
      end
    endcase
    if (go && uw.cnt_ld) begin
      cnt_d = uw.cnt_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_IDLE;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.go   = go;
  assign ctrl_o.idle = (pc_q == PC_IDLE);

endmodule

/* design/skt_datapath.sv */
// Filter datapath: per-axis state, shift-subtract divider, shift-add multipliers.
module skt_datapath #(
  parameter int NUM_AXES    = 3,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  skt_pkg::ctrl_t         ctrl_i,
  input  logic [1:0]             axis_i,
  input  logic [ANGLE_WIDTH-1:0] raw_angle_i,
  input  logic [31:0]            process_noise_i,
  input  logic [31:0]            measurement_noise_i,
  input  logic                   out_ready_i,
  output logic                   bad_o,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  output logic [1:0]             axis_out_o,
  output logic [ANGLE_WIDTH-1:0] filtered_angle_o,
  output logic                   variance_saturated_o
);
  import skt_pkg::*;

  localparam int IdxW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int AW    = ANGLE_WIDTH;
  localparam int MagW  = AW + 1;
  localparam int AccW  = AW + 2;
  localparam int FracW = 30;
  localparam int KW    = FracW + 1;
  localparam int PW    = 32;
  localparam int PaW   = AccW + KW;
  localparam int PbW   = PW + 1 + KW;
  localparam int CorrW = PaW - FracW;
  localparam int PnW   = PbW - FracW;
  localparam logic [KW-1:0] KOne = {1'b1, {FracW{1'b0}}};

  logic [1:0]      axis_q;
  logic [AW-1:0]   raw_q;
  logic            bad_q;
  logic            sat_q;
  logic [PW-1:0]   pp_q;
  logic [PW:0]     den_q;
  logic            kone_q;
  logic [PW:0]     rem_q;
  logic [FracW-1:0] quot_q;
  logic [MagW-1:0] mag_q;
  logic            neg_q;
  logic [AW-1:0]   x_q;
  logic [PaW-1:0]  pa_q;
  logic [PbW-1:0]  pb_q;
  logic [AW-1:0]   est_q [NUM_AXES];
  logic [PW-1:0]   var_q [NUM_AXES];
  logic            ov_q;
  logic [1:0]      oaxis_q;
  logic [AW-1:0]   oangle_q;
  logic            osat_q;

  logic [IdxW-1:0] idx;
  logic [AW-1:0]   est_cur;
  logic [PW:0]     pp_sum;
  logic [PW-1:0]   pp_new;
  logic [PW:0]     den_new;
  logic [MagW-1:0] diff;
  logic [MagW-1:0] mag_new;
  logic [PW+1:0]   rs;
  logic [PW+1:0]   rs_sub;
  logic            ge;
  logic [KW-1:0]   k;
  logic [KW-1:0]   kc;
  logic [AccW-1:0] ta;
  logic [PW:0]     tb;
  logic [CorrW-1:0] corr_full;
  logic [MagW-1:0] corr;
  logic [MagW-1:0] xn;
  logic [PnW-1:0]  p_full;
  logic            step;

  assign step    = ctrl_i.go;
  assign idx     = IdxW'(axis_q);
  assign est_cur = est_q[idx];

  assign pp_sum  = {1'b0, var_q[idx]} + {1'b0, process_noise_i};
  assign pp_new  = pp_sum[PW] ? '1 : pp_sum[PW-1:0];
  assign den_new = {1'b0, pp_new} + {1'b0, measurement_noise_i};
  assign diff    = {raw_q[AW-1], raw_q} - {est_cur[AW-1], est_cur};
  assign mag_new = diff[AW] ? (~diff + MagW'(1)) : diff;

  assign rs     = {rem_q, 1'b0};
  assign rs_sub = rs - {1'b0, den_q};
  assign ge     = (rs >= {1'b0, den_q});

  assign k  = kone_q ? KOne : {1'b0, quot_q};
  assign kc = KOne - k;

  assign ta = pa_q[PaW-1:KW] + (pa_q[0] ? {1'b0, mag_q} : '0);
  assign tb = pb_q[PbW-1:KW] + (pb_q[0] ? {1'b0, pp_q} : '0);

  assign corr_full = pa_q[PaW-1:FracW] + CorrW'(pa_q[FracW-1]);
  assign corr      = corr_full[MagW-1:0];
  assign xn        = neg_q ? ({x_q[AW-1], x_q} - corr) : ({x_q[AW-1], x_q} + corr);
  assign p_full    = pb_q[PbW-1:FracW] + PnW'(pb_q[FracW-1]);

  always_ff @(posedge clk_i) begin
    if (step) begin
      case (ctrl_i.op)
        OP_LATCH: begin
          axis_q <= axis_i;
          raw_q  <= raw_angle_i;
          bad_q  <= (32'(axis_i) >= 32'(NUM_AXES));
        end
        OP_PRED: begin
          pp_q   <= pp_new;
          sat_q  <= pp_sum[PW];
          den_q  <= den_new;
          kone_q <= (measurement_noise_i == '0);
          rem_q  <= {1'b0, pp_new};
          mag_q  <= mag_new;
          neg_q  <= diff[AW];
          x_q    <= est_cur;
        end
        OP_DIV: begin
          rem_q  <= ge ? rs_sub[PW:0] : rs[PW:0];
          quot_q <= {quot_q[FracW-2:0], ge};
        end
        OP_MULI: begin
          pa_q <= {{AccW{1'b0}}, k};
          pb_q <= {{(PW + 1){1'b0}}, kc};
        end
        OP_MUL: begin
          pa_q <= {ta, pa_q[KW-1:0]} >> 1;
          pb_q <= {tb, pb_q[KW-1:0]} >> 1;
        end
        OP_WB: begin
          x_q <= xn[AW-1:0];
        end
        OP_OUT: begin
          oaxis_q  <= axis_q;
          oangle_q <= bad_q ? '0 : x_q;
          osat_q   <= bad_q ? 1'b0 : sat_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        est_q[i] <= '0;
        var_q[i] <= '0;
      end
    end else if (step && ctrl_i.op == OP_WB) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (idx == IdxW'(i)) begin
          est_q[i] <= xn[AW-1:0];
          var_q[i] <= p_full[PW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (step && ctrl_i.op == OP_OUT) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign bad_o                = bad_q;
  assign out_free_o           = !ov_q || out_ready_i;
  assign out_valid_o          = ov_q;
  assign axis_out_o           = oaxis_q;
  assign filtered_angle_o     = oangle_q;
  assign variance_saturated_o = osat_q;

endmodule

/* design/scalar_kalman_three_axis.sv */
// Top level of the three-axis scalar Kalman filter.
//
// Each input beat on the slave stream carries one raw angle sample (signed
// Q16.16) in tdata and its axis in tuser. The block predicts the variance of
// that axis, forms the gain with a restoring divider of one quotient bit per
// cycle, applies it with two shift-add multipliers of one gain bit per cycle,
// and sends one beat on the master stream: the new estimate in tdata, the
// axis and a variance saturation flag in tuser.
// The control program runs 30 divider steps and 31 multiplier steps for
// each item; a new beat is accepted once the program has returned to its
// first step. An axis outside the filter's range leaves all state alone
// and returns a beat with a zero estimate and a clear flag.
// Reset clears every estimate and variance and loads the noise registers with
// their default values. A stalled receiver holds the result in the output
// register; the next item is accepted and computed meanwhile and waits for
// that register to drain. Noise registers must be written through the plain
// write port only while the filter is idle; the block does not enforce it.
module scalar_kalman_three_axis #(
  parameter int NUM_AXES    = 3,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // raw_angle
  input  logic [((ANGLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  // axis
  input  logic [1:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // filtered_angle
  output logic [((ANGLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
  // axis_out, variance_saturated
  output logic [2:0]                            m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [31:0]                           cfg_data_i
);
  import skt_pkg::*;

  localparam int DataW = ((ANGLE_WIDTH + 7) / 8) * 8;

  logic [31:0]            process_noise_q;
  logic [31:0]            measurement_noise_q;
  ctrl_t                  ctrl;
  seq_stat_t              stat;
  logic                   bad;
  logic                   out_free;
  logic [1:0]             axis_out;
  logic [ANGLE_WIDTH-1:0] filtered_angle;
  logic                   variance_saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_noise_q     <= PROCESS_NOISE_RESET;
      measurement_noise_q <= MEASUREMENT_NOISE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROCESS_NOISE:     process_noise_q     <= cfg_data_i;
        REG_MEASUREMENT_NOISE: measurement_noise_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = ctrl.idle;
  assign stat.in_fire  = s_axis_tvalid && ctrl.idle;
  assign stat.out_free = out_free;
  assign stat.bad      = bad;

  skt_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  skt_datapath #(
    .NUM_AXES    (NUM_AXES),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctrl_i               (ctrl),
    .axis_i               (s_axis_tuser),
    .raw_angle_i          (s_axis_tdata[ANGLE_WIDTH-1:0]),
    .process_noise_i      (process_noise_q),
    .measurement_noise_i  (measurement_noise_q),
    .out_ready_i          (m_axis_tready),
    .bad_o                (bad),
    .out_free_o           (out_free),
    .out_valid_o          (m_axis_tvalid),
    .axis_out_o           (axis_out),
    .filtered_angle_o     (filtered_angle),
    .variance_saturated_o (variance_saturated)
  );

  assign m_axis_tdata = DataW'(filtered_angle);
  assign m_axis_tuser = {variance_saturated, axis_out};

endmodule
